// ===== hw/rtl/fls_pkg.sv =====
`timescale 1ns / 1ps

package fls_pkg;

    localparam int DEPTH       = 16;
    localparam int SAMPLE_BITS = 16;
    localparam int SMP_W       = 16;
    localparam int NUM_SMP     = 4;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CNT_W       = $clog2(DEPTH + 1);
    localparam int FILL_W      = 5;
    localparam int IN_DATA_W   = 72;
    localparam int OUT_DATA_W  = 80;

    typedef logic signed [SMP_W-1:0] sample_t;
    typedef sample_t [NUM_SMP-1:0] quad_t;

    typedef struct packed {
        logic  reset_gate;
        logic  push_gate;
        logic  pop_gate;
        quad_t samples;
    } in_item_t;

    typedef struct packed {
        quad_t             held;
        logic              overflow_flag;
        logic              underflow_flag;
        logic              full_flag;
        logic              empty_flag;
        logic [FILL_W-1:0] fill_level;
    } out_item_t;

    // keep the low SAMPLE_BITS bits as a two's complement value
    function automatic sample_t keep_sample(input sample_t v);
        logic signed [SAMPLE_BITS-1:0] t;
        begin
            t = v[SAMPLE_BITS-1:0];
            return SMP_W'(t);
        end
    endfunction

endpackage

// ===== hw/rtl/fls_in_stage.sv =====
`timescale 1ns / 1ps

module fls_in_stage
    import fls_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [IN_DATA_W-1:0] s_tdata,
    output logic                 item_valid,
    output in_item_t             item,
    input  logic                 item_take
);

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;
    in_item_t item_next;
    logic     load;

    // holds one beat while the core is stalled
    assign s_tready = !valid_reg || item_take;
    assign load     = s_tvalid && s_tready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (item_take)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        item_next            = item_reg;
        if (load)
        begin
            item_next.reset_gate = s_tdata[0];
            item_next.push_gate  = s_tdata[1];
            item_next.pop_gate   = s_tdata[2];
            item_next.samples    = s_tdata[3 +: NUM_SMP*SMP_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/fls_core.sv =====
`timescale 1ns / 1ps

module fls_core
    import fls_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      cfg_wr_en,
    input  logic      cfg_wr_data,
    input  logic      item_valid,
    input  in_item_t  item,
    output logic      item_take,
    output logic      res_valid,
    input  logic      res_take,
    output out_item_t res
);

    quad_t             store_mem [DEPTH];

    logic              mode_reg;
    logic [2:0]        prior_reg;
    logic [IDX_W-1:0]  oldest_reg;
    logic [CNT_W-1:0]  count_reg;
    quad_t             held_reg;
    logic              ovf_reg;
    logic              unf_reg;
    logic              out_valid_reg;
    out_item_t         out_reg;

    logic [2:0]        prior_next;
    logic [IDX_W-1:0]  oldest_next;
    logic [CNT_W-1:0]  count_next;
    quad_t             held_next;
    logic              ovf_next;
    logic              unf_next;
    logic              out_valid_next;
    out_item_t         out_next;

    logic              step;
    logic [2:0]        levels;
    logic [2:0]        rise;
    logic              gated;
    logic              do_push;
    logic              push_ok;
    logic              do_pop;
    logic [CNT_W-1:0]  count_mid;
    logic [IDX_W-1:0]  wr_idx;
    logic [IDX_W-1:0]  rd_idx;
    quad_t             push_data;
    quad_t             rd_data;

    // slot arithmetic: sum stays below twice the depth
    function automatic logic [IDX_W-1:0] wrap_idx(input logic [CNT_W:0] sum);
        logic [CNT_W:0] t;
        begin
            t = (sum >= (CNT_W+1)'(DEPTH)) ? sum - (CNT_W+1)'(DEPTH) : sum;
            return t[IDX_W-1:0];
        end
    endfunction

    assign item_take = !out_valid_reg || res_take;
    assign step      = item_valid && item_take;

    assign levels  = {item.pop_gate, item.push_gate, item.reset_gate};
    assign rise    = levels & ~prior_reg;
    // reset level high (edge or held) blocks push and pop
    assign gated   = !levels[0];
    assign do_push = gated && rise[1];
    assign push_ok = do_push && (count_reg < CNT_W'(DEPTH));
    assign do_pop  = gated && rise[2];

    assign count_mid = push_ok ? count_reg + CNT_W'(1) : count_reg;

    always_comb
    begin
        for (int i = 0; i < NUM_SMP; i++)
        begin
            push_data[i] = keep_sample(item.samples[i]);
        end
    end

    assign wr_idx = wrap_idx((CNT_W+1)'(oldest_reg) + (CNT_W+1)'(count_reg));
    assign rd_idx = mode_reg
                  ? wrap_idx((CNT_W+1)'(oldest_reg) + (CNT_W+1)'(count_mid) - (CNT_W+1)'(1))
                  : oldest_reg;

    // a pop can take the entry pushed in the same beat
    assign rd_data = (push_ok && (rd_idx == wr_idx)) ? push_data : store_mem[rd_idx];

    always_comb
    begin
        prior_next     = prior_reg;
        oldest_next    = oldest_reg;
        count_next     = count_reg;
        held_next      = held_reg;
        ovf_next       = ovf_reg;
        unf_next       = unf_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;

        if (res_take)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_wr_en)
        begin
            oldest_next = '0;
            count_next  = '0;
            ovf_next    = 1'b0;
            unf_next    = 1'b0;
        end
        else if (step)
        begin
            prior_next = levels;
            if (rise[0])
            begin
                oldest_next = '0;
                count_next  = '0;
                ovf_next    = 1'b0;
                unf_next    = 1'b0;
            end
            else if (gated)
            begin
                if (do_push)
                begin
                    unf_next   = 1'b0;
                    ovf_next   = !push_ok;
                    count_next = count_mid;
                end
                if (do_pop)
                begin
                    ovf_next = 1'b0;
                    if (count_mid == '0)
                    begin
                        held_next = '0;
                        unf_next  = 1'b1;
                    end
                    else
                    begin
                        held_next  = rd_data;
                        count_next = count_mid - CNT_W'(1);
                        unf_next   = 1'b0;
                        if (!mode_reg)
                        begin
                            oldest_next = wrap_idx((CNT_W+1)'(oldest_reg) + (CNT_W+1)'(1));
                        end
                    end
                end
            end
        end

        if (step)
        begin
            out_valid_next          = 1'b1;
            out_next.held           = held_next;
            out_next.overflow_flag  = ovf_next;
            out_next.underflow_flag = unf_next;
            out_next.full_flag      = (count_next == CNT_W'(DEPTH));
            out_next.empty_flag     = (count_next == '0);
            out_next.fill_level     = FILL_W'(count_next);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= 1'b0;
            prior_reg     <= '0;
            oldest_reg    <= '0;
            count_reg     <= '0;
            held_reg      <= '0;
            ovf_reg       <= 1'b0;
            unf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            prior_reg     <= prior_next;
            oldest_reg    <= oldest_next;
            count_reg     <= count_next;
            held_reg      <= held_next;
            ovf_reg       <= ovf_next;
            unf_reg       <= unf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
        if (!cfg_wr_en && step && push_ok)
        begin
            store_mem[wr_idx] <= push_data;
        end
    end

    assign res_valid = out_valid_reg;
    assign res       = out_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_flags_excl: assert property (@(posedge clk) disable iff (!rst_n)
        !(ovf_reg && unf_reg))
        else $error("overflow and underflow both set");

    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_wr_en |=> (count_reg == '0) && !ovf_reg && !unf_reg)
        else $error("mode write did not empty the store");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !res_take) |=> out_valid_reg && $stable(out_reg))
        else $error("stalled result changed");
`endif

endmodule

// ===== hw/rtl/fifo_lifo_sample_stack_unit.sv =====
// an accepted input beat is held in the input stage register, then in the core result register
// throughput: one beat per cycle while the output side takes results
// each beat is one sample tick: edge detect, one indexed write and one read of
// the 16-entry register store, then the result register
// rst_n clears the store pointers, fill count, flags, held samples, gate history
// and order mode; store contents stay undefined until written
`timescale 1ns / 1ps

module fifo_lifo_sample_stack_unit
    import fls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,   // order_mode: 0 fifo, 1 lifo
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // reset_gate, push_gate, pop_gate, sample_a, sample_b, sample_c, sample_d, zero pad
    input  logic [IN_DATA_W-1:0]  s_tdata,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // held_a, held_b, held_c, held_d, overflow_flag, underflow_flag,
    // full_flag, empty_flag, fill_level, zero pad
    output logic [OUT_DATA_W-1:0] m_tdata
);

    logic      item_valid;
    in_item_t  item;
    logic      item_take;
    out_item_t res;

    fls_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take)
    );

    fls_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take),
        .res_valid   (m_tvalid),
        .res_take    (m_tready),
        .res         (res)
    );

    assign m_tdata = {
        (OUT_DATA_W - NUM_SMP*SMP_W - 4 - FILL_W)'(0),
        res.fill_level,
        res.empty_flag,
        res.full_flag,
        res.underflow_flag,
        res.overflow_flag,
        res.held
    };

endmodule

// ===== dv/fls_stack_checker.sv =====
`timescale 1ns / 1ps

module fls_stack_checker
    import fls_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_wr_en,
    input  logic                  cfg_wr_data,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [OUT_DATA_W-1:0] m_tdata,
    output int                    errors,
    output int                    pending
);

    localparam int QUAD_W   = NUM_SMP * SMP_W;
    localparam int SMP_BASE = 3;
    localparam int OVF_BIT  = QUAD_W;
    localparam int UNF_BIT  = QUAD_W + 1;
    localparam int FULL_BIT = QUAD_W + 2;
    localparam int EMPT_BIT = QUAD_W + 3;
    localparam int FILL_LSB = QUAD_W + 4;
    localparam int PAD_LSB  = FILL_LSB + FILL_W;

    logic [QUAD_W-1:0]     entries [DEPTH];
    int unsigned           head;
    int unsigned           count;
    logic [QUAD_W-1:0]     held;
    logic                  ovf;
    logic                  unf;
    logic                  lifo;
    logic [2:0]            prev_gates;
    logic [OUT_DATA_W-1:0] tick_results_q [$];

    int n_ticks;
    int n_pushes;
    int n_pops;
    int n_lifo_pops;
    int n_overflows;
    int n_underflows;
    int n_full;

    task automatic report(string what, logic [63:0] got, logic [63:0] want);
        errors++;
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
    endtask

    task automatic field_check(string what, logic [63:0] got, logic [63:0] want);
        if (got !== want)
            report(what, got, want);
    endtask

    task automatic empty_entries();
        head  = 0;
        count = 0;
        ovf   = 1'b0;
        unf   = 1'b0;
    endtask

    // only the low SAMPLE_BITS of each sample survive, sign-extended back
    function automatic logic [QUAD_W-1:0] trim_quad(input logic [QUAD_W-1:0] raw);
        logic [QUAD_W-1:0]             r;
        logic signed [SAMPLE_BITS-1:0] t;
        for (int i = 0; i < NUM_SMP; i++)
        begin
            t = raw[i*SMP_W +: SAMPLE_BITS];
            r[i*SMP_W +: SMP_W] = SMP_W'(t);
        end
        return r;
    endfunction

    task automatic predict_tick(input logic [IN_DATA_W-1:0] beat,
                                output logic [OUT_DATA_W-1:0] res);
        logic [2:0]  lv;
        logic [2:0]  rise;
        int unsigned slot;
        lv         = beat[2:0];
        rise       = lv & ~prev_gates;
        prev_gates = lv;
        n_ticks++;
        if (rise[0])
        begin
            empty_entries();
        end
        else if (!lv[0])
        begin
            // push is handled before pop within one tick
            if (rise[1])
            begin
                unf = 1'b0;
                if (count >= DEPTH)
                begin
                    ovf = 1'b1;
                    n_overflows++;
                end
                else
                begin
                    slot = (head + count) % DEPTH;
                    entries[slot] = trim_quad(beat[SMP_BASE +: QUAD_W]);
                    count++;
                    ovf = 1'b0;
                    n_pushes++;
                end
            end
            if (rise[2])
            begin
                ovf = 1'b0;
                if (count == 0)
                begin
                    held = '0;
                    unf  = 1'b1;
                    n_underflows++;
                end
                else
                begin
                    if (lifo)
                    begin
                        slot = (head + count - 1) % DEPTH;
                        n_lifo_pops++;
                    end
                    else
                    begin
                        slot = head;
                        head = (head + 1) % DEPTH;
                    end
                    held = entries[slot];
                    count--;
                    unf = 1'b0;
                    n_pops++;
                end
            end
        end
        if (count == DEPTH)
            n_full++;
        res = '0;
        res[QUAD_W-1:0]           = held;
        res[OVF_BIT]              = ovf;
        res[UNF_BIT]              = unf;
        res[FULL_BIT]             = (count == DEPTH);
        res[EMPT_BIT]             = (count == 0);
        res[FILL_LSB +: FILL_W]   = FILL_W'(count);
    endtask

    task automatic compare_beat(logic [OUT_DATA_W-1:0] got, logic [OUT_DATA_W-1:0] want);
        for (int i = 0; i < NUM_SMP; i++)
            field_check($sformatf("held sample %0d", i),
                        64'(got[i*SMP_W +: SMP_W]), 64'(want[i*SMP_W +: SMP_W]));
        field_check("overflow_flag", 64'(got[OVF_BIT]), 64'(want[OVF_BIT]));
        field_check("underflow_flag", 64'(got[UNF_BIT]), 64'(want[UNF_BIT]));
        field_check("full_flag", 64'(got[FULL_BIT]), 64'(want[FULL_BIT]));
        field_check("empty_flag", 64'(got[EMPT_BIT]), 64'(want[EMPT_BIT]));
        field_check("fill_level", 64'(got[FILL_LSB +: FILL_W]),
                    64'(want[FILL_LSB +: FILL_W]));
        field_check("pad bits", 64'(got[OUT_DATA_W-1:PAD_LSB]), 64'(0));
    endtask

    always @(posedge clk)
    begin
        logic [OUT_DATA_W-1:0] want;
        if (!rst_n)
        begin
            empty_entries();
            held         = '0;
            lifo         = 1'b0;
            prev_gates   = '0;
            errors       = 0;
            pending      = 0;
            n_ticks      = 0;
            n_pushes     = 0;
            n_pops       = 0;
            n_lifo_pops  = 0;
            n_overflows  = 0;
            n_underflows = 0;
            n_full       = 0;
            tick_results_q.delete();
        end
        else
        begin
            // a mode write empties the store but keeps held samples and gate history
            if (cfg_wr_en)
            begin
                lifo = cfg_wr_data;
                empty_entries();
            end
            if (m_tvalid && m_tready)
            begin
                if (tick_results_q.size() == 0)
                    report("result beat with nothing expected", 64'(m_tdata), 64'(0));
                else
                    compare_beat(m_tdata, tick_results_q.pop_front());
            end
            if (s_tvalid && s_tready)
            begin
                predict_tick(s_tdata, want);
                tick_results_q.push_back(want);
            end
            pending = tick_results_q.size();
        end
    end

endmodule

// ===== dv/fifo_lifo_sample_stack_unit_tb.sv =====
`timescale 1ns / 1ps

module fifo_lifo_sample_stack_unit_tb;
    import fls_pkg::*;

    localparam logic [2:0] GATE_RESET = 3'b001;
    localparam logic [2:0] GATE_PUSH  = 3'b010;
    localparam logic [2:0] GATE_POP   = 3'b100;
    localparam logic [2:0] GATE_NONE  = 3'b000;
    localparam logic       MODE_FIFO  = 1'b0;
    localparam logic       MODE_LIFO  = 1'b1;
    localparam int         QUAD_W     = NUM_SMP * SMP_W;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_wr_en;
    logic                  cfg_wr_data;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [IN_DATA_W-1:0]  s_tdata;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [OUT_DATA_W-1:0] m_tdata;

    int         errors;
    int         pending;
    int         idle_pct    = 0;
    int         stall_pct   = 0;
    int         hold_cycles = 0;
    int         sent        = 0;
    logic [2:0] gates;

    fifo_lifo_sample_stack_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    fls_stack_checker chk (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .errors      (errors),
        .pending     (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("FAIL fifo_lifo_sample_stack_unit");
        $finish;
    end

    // output side: random stalls, or a counted hold-off when one is requested
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_cycles > 0)
            begin
                m_tready <= 1'b0;
                hold_cycles--;
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= stall_pct);
            end
        end
    end

    function automatic logic [SMP_W-1:0] pick_sample();
        case ($urandom_range(7))
            0:       return 16'h8000;
            1:       return 16'h7fff;
            2:       return 16'h0000;
            3:       return 16'hffff;
            default: return SMP_W'($urandom);
        endcase
    endfunction

    function automatic logic [QUAD_W-1:0] pick_quad();
        return {pick_sample(), pick_sample(), pick_sample(), pick_sample()};
    endfunction

    task automatic send_tick(logic [2:0] g, logic [QUAD_W-1:0] quad);
        @(negedge clk);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_DATA_W-QUAD_W-3){1'b0}}, quad, g};
        do
            @(posedge clk);
        while (!s_tready);
        gates = g;
        sent++;
    endtask

    task automatic settle();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_mode(logic v);
        settle();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(negedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    task automatic run_directed();
        // first push counts as an edge right after reset, then underflow,
        // reset edge swallowing push and pop, held reset blocking, push+pop together
        send_tick(GATE_PUSH, {16'hffff, 16'h0000, 16'h7fff, 16'h8000});
        send_tick(GATE_POP, pick_quad());
        send_tick(GATE_NONE, pick_quad());
        send_tick(GATE_POP, pick_quad());
        send_tick(GATE_PUSH, {16'h0000, 16'hffff, 16'h8000, 16'h7fff});
        send_tick(GATE_NONE, pick_quad());
        send_tick(GATE_RESET | GATE_PUSH | GATE_POP, pick_quad());
        send_tick(GATE_RESET | GATE_PUSH, pick_quad());
        send_tick(GATE_RESET | GATE_POP, pick_quad());
        send_tick(GATE_PUSH, pick_quad());
        send_tick(GATE_NONE, pick_quad());
        send_tick(GATE_PUSH | GATE_POP, pick_quad());
    endtask

    task automatic random_run(int n);
        int         left;
        int         kind;
        int         len;
        logic [2:0] g;
        left = n;
        while (left > 0)
        begin
            kind = $urandom_range(99);
            len  = $urandom_range(6, 40);
            if (kind < 4)
            begin
                // let everything drain before going on
                settle();
                continue;
            end
            repeat (len)
            begin
                if (left > 0)
                begin
                    g = gates;
                    if (kind < 38)
                    begin
                        // toggling push fills the store and runs into overflow
                        g = {1'b0, ~g[1], 1'b0};
                    end
                    else if (kind < 66)
                    begin
                        g = {~g[2], 1'b0, 1'b0};
                    end
                    else if (kind < 92)
                    begin
                        g = {2'($urandom), 1'b0};
                    end
                    else
                    begin
                        g = 3'($urandom);
                    end
                    send_tick(g, pick_quad());
                    left--;
                end
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        gates       = GATE_NONE;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        write_mode(MODE_FIFO);
        run_directed();
        write_mode(MODE_LIFO);
        run_directed();

        idle_pct  = 0;
        stall_pct = 0;
        write_mode(MODE_FIFO);
        random_run(340);

        idle_pct  = 55;
        stall_pct = 0;
        write_mode(MODE_LIFO);
        random_run(170);
        settle();
        random_run(170);

        idle_pct  = 0;
        stall_pct = 55;
        write_mode(MODE_LIFO);
        random_run(340);

        idle_pct  = 6;
        stall_pct = 6;
        write_mode(MODE_FIFO);
        random_run(340);

        // long output hold while ticks keep coming, so the input side backs up
        idle_pct  = 0;
        stall_pct = 0;
        write_mode(MODE_LIFO);
        hold_cycles = 300;
        random_run(80);

        settle();
        repeat (8) @(negedge clk);

        $display("run: %0d ticks, %0d pushes, %0d pops (%0d in lifo order)",
                 chk.n_ticks, chk.n_pushes, chk.n_pops, chk.n_lifo_pops);
        $display("%0d overflows, %0d underflows, store full on %0d ticks; %s",
                 chk.n_overflows, chk.n_underflows, chk.n_full,
                 "both orders, mode rewrites, idle and stall mixes, long hold");
        if (errors == 0 && pending == 0)
            $display("PASS fifo_lifo_sample_stack_unit");
        else
            $display("FAIL fifo_lifo_sample_stack_unit");
        $finish;
    end

endmodule

// ===== fifo_lifo_sample_stack_unit.f =====
hw/rtl/fls_pkg.sv
hw/rtl/fls_in_stage.sv
hw/rtl/fls_core.sv
hw/rtl/fifo_lifo_sample_stack_unit.sv
dv/fls_stack_checker.sv
dv/fifo_lifo_sample_stack_unit_tb.sv
